### src/lsd_pkg.sv
package lsd_pkg;

   localparam int LSD_LEVEL_BITS = 12;
   localparam int TIMER_BITS = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int OPCODE_BITS = 3;

   localparam logic [TIMER_BITS-1:0] FLASH_TICKS_RESET = TIMER_BITS'(100);
   localparam int STEP_SIZE_RESET = 16;

   localparam logic [1:0] BLINK_LAST_PHASE = 2'd3;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_TICK    = 3'd0,
      OP_STEP    = 3'd1,
      OP_REVERSE = 3'd2,
      OP_TURN_ON = 3'd3,
      OP_OFF     = 3'd4
   } opcode_type;

   typedef enum logic [0:0] {
      REG_STEP_SIZE   = 1'b0,
      REG_FLASH_TICKS = 1'b1
   } reg_index_type;

endpackage

### src/led_step_dimmer_with_limit_flash_core.sv
// Two-channel lamp level controller with boundary blink.
// Request channel: req_valid/req_stall carry an opcode (tick, step, reverse,
// turn on, turn off), the battery limit and, for turn on, mode and level.
// Response channel: rsp_valid/rsp_stall return one response per request with
// the cool and warm drive levels, the stored level and lamp/blink status.
// Configuration: APB-style csr_ port; step size at 0x0, blink phase length in
// ticks at 0x4. Write only while no request is outstanding.
// Responses are registered, in the skid register when an older one still waits.
// Throughput: one request per cycle while req_stall is low; all state updates in a
// single add and compare stage between the request and the response register.
// Stall: a two-entry output (response register plus skid register) lets one
// further request in while a response waits; req_stall rises once the skid
// register holds a response, and lowers when the receiver takes one.
// Reset: lamp off, warm selected, level at full scale, direction down, no
// blink, step size 16, blink phase 100 ticks; no response pending.
module led_step_dimmer_with_limit_flash_core
   import lsd_pkg::*;
#(
   parameter int LEVEL_BITS = LSD_LEVEL_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OPCODE_BITS-1:0]   req_opcode,
   input  logic [LEVEL_BITS-1:0]    req_battery_limit,
   input  logic                     req_cool_mode,
   input  logic [LEVEL_BITS-1:0]    req_level_request,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [LEVEL_BITS-1:0]    rsp_cool_drive,
   output logic [LEVEL_BITS-1:0]    rsp_warm_drive,
   output logic [LEVEL_BITS-1:0]    rsp_current_level,
   output logic                     rsp_lamp_is_on,
   output logic                     rsp_flashing,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int RES_BITS = 3 * LEVEL_BITS + 2;

   logic [LEVEL_BITS-1:0] step_size_ff;
   logic [TIMER_BITS-1:0] flash_ticks_ff;
   logic                  csr_write;
   reg_index_type         csr_index;

   logic                  accept;
   logic                  pop;
   logic [RES_BITS-1:0]   res_new;
   logic [RES_BITS-1:0]   out_ff, out_in;
   logic [RES_BITS-1:0]   skid_ff, skid_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;

   logic [LEVEL_BITS-1:0] core_cool;
   logic [LEVEL_BITS-1:0] core_warm;
   logic [LEVEL_BITS-1:0] core_level;
   logic                  core_on;
   logic                  core_flash;

   assign csr_pready = 1'b1;
   assign csr_index = reg_index_type'(csr_paddr[2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         REG_STEP_SIZE:   csr_prdata = CSR_DATA_BITS'(step_size_ff);
         REG_FLASH_TICKS: csr_prdata = CSR_DATA_BITS'(flash_ticks_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= LEVEL_BITS'(STEP_SIZE_RESET);
         flash_ticks_ff <= FLASH_TICKS_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_STEP_SIZE) begin
            step_size_ff <= csr_pwdata[LEVEL_BITS-1:0];
         end else begin
            flash_ticks_ff <= csr_pwdata[TIMER_BITS-1:0];
         end
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !req_stall;
   assign pop = out_valid_ff && !rsp_stall;

   lsd_core #(
      .LEVEL_BITS(LEVEL_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .opcode           (req_opcode),
      .battery_limit    (req_battery_limit),
      .cool_mode        (req_cool_mode),
      .level_request    (req_level_request),
      .step_size        (step_size_ff),
      .flash_phase_ticks(flash_ticks_ff),
      .cool_drive       (core_cool),
      .warm_drive       (core_warm),
      .current_level    (core_level),
      .lamp_is_on       (core_on),
      .flashing         (core_flash)
   );

   assign res_new = {core_cool, core_warm, core_level, core_on, core_flash};

   always_comb begin
      out_in = out_ff;
      skid_in = skid_ff;
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_in = res_new;
            skid_valid_in = 1'b1;
         end else begin
            out_in = res_new;
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_cool_drive = out_ff[RES_BITS-1 -: LEVEL_BITS];
   assign rsp_warm_drive = out_ff[2*LEVEL_BITS+1 -: LEVEL_BITS];
   assign rsp_current_level = out_ff[LEVEL_BITS+1 -: LEVEL_BITS];
   assign rsp_lamp_is_on = out_ff[1];
   assign rsp_flashing = out_ff[0];

   skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while response register empty");

   one_channel_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cool_drive == '0) || (rsp_warm_drive == '0))
      else $error("both channels driven");

   flash_needs_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flashing |-> rsp_lamp_is_on)
      else $error("blink reported with lamp off");

   accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

endmodule

### src/lsd_core.sv
module lsd_core
   import lsd_pkg::*;
#(
   parameter int LEVEL_BITS = LSD_LEVEL_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [OPCODE_BITS-1:0] opcode,
   input  logic [LEVEL_BITS-1:0]  battery_limit,
   input  logic                   cool_mode,
   input  logic [LEVEL_BITS-1:0]  level_request,
   input  logic [LEVEL_BITS-1:0]  step_size,
   input  logic [TIMER_BITS-1:0]  flash_phase_ticks,
   output logic [LEVEL_BITS-1:0]  cool_drive,
   output logic [LEVEL_BITS-1:0]  warm_drive,
   output logic [LEVEL_BITS-1:0]  current_level,
   output logic                   lamp_is_on,
   output logic                   flashing
);

   logic                  lamp_on_ff, lamp_on_in;
   logic                  cool_ff, cool_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic                  dimming_ff, dimming_in;
   logic                  blink_active_ff, blink_active_in;
   logic [1:0]            blink_phase_ff, blink_phase_in;
   logic [TIMER_BITS-1:0] blink_timer_ff, blink_timer_in;
   logic [LEVEL_BITS-1:0] blink_level_ff, blink_level_in;

   logic signed [LEVEL_BITS+1:0] step_next;
   logic signed [LEVEL_BITS+1:0] limit_ext;
   logic signed [LEVEL_BITS+1:0] step_ext;
   logic [TIMER_BITS-1:0]        timer_inc;
   logic [LEVEL_BITS-1:0]        shown;
   opcode_type                   op;

   always_comb begin
      op = opcode_type'(opcode);
      limit_ext = $signed({2'b00, battery_limit});
      step_ext = $signed({2'b00, step_size});
      if (dimming_ff) begin
         step_next = $signed({2'b00, level_ff}) - step_ext;
      end else begin
         step_next = $signed({2'b00, level_ff}) + step_ext;
      end
      timer_inc = (blink_timer_ff != '1) ? blink_timer_ff + 1'b1 : blink_timer_ff;

      lamp_on_in = lamp_on_ff;
      cool_in = cool_ff;
      level_in = level_ff;
      dimming_in = dimming_ff;
      blink_active_in = blink_active_ff;
      blink_phase_in = blink_phase_ff;
      blink_timer_in = blink_timer_ff;
      blink_level_in = blink_level_ff;

      unique case (op)
         OP_TICK: begin
            if (blink_active_ff) begin
               if (timer_inc >= flash_phase_ticks) begin
                  blink_timer_in = '0;
                  if (blink_phase_ff == BLINK_LAST_PHASE) begin
                     blink_active_in = 1'b0;
                     blink_phase_in = '0;
                  end else begin
                     blink_phase_in = blink_phase_ff + 1'b1;
                  end
               end else begin
                  blink_timer_in = timer_inc;
               end
            end
         end
         OP_STEP: begin
            if (lamp_on_ff) begin
               if (step_next >= limit_ext) begin
                  level_in = battery_limit;
                  if (level_ff != battery_limit) begin
                     blink_level_in = battery_limit;
                     blink_phase_in = '0;
                     blink_timer_in = '0;
                     blink_active_in = 1'b1;
                  end
               end else if (step_next <= step_ext) begin
                  level_in = (step_size > battery_limit) ? battery_limit : step_size;
                  if (level_ff != step_size) begin
                     blink_level_in = step_size;
                     blink_phase_in = '0;
                     blink_timer_in = '0;
                     blink_active_in = 1'b1;
                  end
               end else begin
                  level_in = step_next[LEVEL_BITS-1:0];
               end
            end
         end
         OP_REVERSE: begin
            dimming_in = ~dimming_ff;
         end
         OP_TURN_ON: begin
            lamp_on_in = 1'b1;
            cool_in = cool_mode;
            level_in = (level_request > battery_limit) ? battery_limit : level_request;
         end
         OP_OFF: begin
            lamp_on_in = 1'b0;
            blink_active_in = 1'b0;
            blink_phase_in = '0;
            blink_timer_in = '0;
         end
         default: begin
         end
      endcase

      shown = '0;
      if (lamp_on_in) begin
         if (blink_active_in) begin
            shown = blink_phase_in[0] ? blink_level_in : '0;
         end else begin
            shown = level_in;
         end
      end
      cool_drive = cool_in ? shown : '0;
      warm_drive = cool_in ? '0 : shown;
      current_level = level_in;
      lamp_is_on = lamp_on_in;
      flashing = blink_active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_on_ff <= 1'b0;
         cool_ff <= 1'b0;
         level_ff <= '1;
         dimming_ff <= 1'b1;
         blink_active_ff <= 1'b0;
         blink_phase_ff <= '0;
         blink_timer_ff <= '0;
         blink_level_ff <= '0;
      end else if (accept) begin
         lamp_on_ff <= lamp_on_in;
         cool_ff <= cool_in;
         level_ff <= level_in;
         dimming_ff <= dimming_in;
         blink_active_ff <= blink_active_in;
         blink_phase_ff <= blink_phase_in;
         blink_timer_ff <= blink_timer_in;
         blink_level_ff <= blink_level_in;
      end
   end

   bl_needs_lamp: assert property (@(posedge clock) disable iff (reset)
      blink_active_ff |-> lamp_on_ff)
      else $error("blink active while lamp off");

   phase_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !blink_active_ff |-> (blink_phase_ff == '0))
      else $error("blink phase not cleared when idle");

   hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      $past(!accept) && !$past(reset) |-> $stable(level_ff) && $stable(lamp_on_ff))
      else $error("state changed without a request");

endmodule

### sim/tb_top.sv
module tb_top;
   import lsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LB = LSD_LEVEL_BITS;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int HOLD_CYCLES = 60;
   localparam logic [OPCODE_BITS-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPCODE_BITS-1:0] OP_SPARE_LAST = 3'd7;
   localparam logic [LB-1:0] LEVEL_FULL = '1;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [LB-1:0]          limit;
      logic                   cool_mode;
      logic [LB-1:0]          level_req;
   } lamp_cmd_type;

   typedef struct packed {
      logic [LB-1:0] cool_drive;
      logic [LB-1:0] warm_drive;
      logic [LB-1:0] level;
      logic          lamp_on;
      logic          flashing;
   } lamp_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OPCODE_BITS-1:0]   req_opcode = '0;
   logic [LB-1:0]            req_battery_limit = '0;
   logic                     req_cool_mode = 1'b0;
   logic [LB-1:0]            req_level_request = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [LB-1:0]            rsp_cool_drive;
   logic [LB-1:0]            rsp_warm_drive;
   logic [LB-1:0]            rsp_current_level;
   logic                     rsp_lamp_is_on;
   logic                     rsp_flashing;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   lamp_cmd_type pending_q[$];
   lamp_out_type expected_q[$];
   lamp_cmd_type next_cmd;
   lamp_out_type seen_out;

   int  req_issued = 0;
   int  req_accepted = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_trigger = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   bit  cycle_busy;
   bit  failed = 1'b0;

   // lamp state as the block should hold it
   logic [LB-1:0] step_size_q = LB'(STEP_SIZE_RESET);
   logic [15:0]   phase_ticks_q = FLASH_TICKS_RESET;
   logic          lamp_on_q = 1'b0;
   logic          cool_sel_q = 1'b0;
   logic [LB-1:0] level_q = LEVEL_FULL;
   logic          dimming_q = 1'b1;
   logic          blink_on_q = 1'b0;
   logic [2:0]    blink_phase_q = '0;
   logic [15:0]   blink_timer_q = '0;
   logic [LB-1:0] blink_level_q = '0;

   led_step_dimmer_with_limit_flash_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_battery_limit (req_battery_limit),
      .req_cool_mode     (req_cool_mode),
      .req_level_request (req_level_request),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cool_drive    (rsp_cool_drive),
      .rsp_warm_drive    (rsp_warm_drive),
      .rsp_current_level (rsp_current_level),
      .rsp_lamp_is_on    (rsp_lamp_is_on),
      .rsp_flashing      (rsp_flashing),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic void begin_blink();
      blink_level_q = level_q;
      blink_phase_q = '0;
      blink_timer_q = '0;
      blink_on_q = 1'b1;
   endfunction

   function automatic lamp_out_type lamp_update(lamp_cmd_type cmd);
      lamp_out_type  res;
      logic [LB-1:0] old_level;
      logic [LB-1:0] shown;
      int            next_level;
      shown = '0;
      case (cmd.opcode)
         OP_TICK: begin
            if (blink_on_q) begin
               if (blink_timer_q != 16'hFFFF)
                  blink_timer_q = blink_timer_q + 16'd1;
               if (blink_timer_q >= phase_ticks_q) begin
                  blink_timer_q = '0;
                  blink_phase_q = blink_phase_q + 3'd1;
                  if (blink_phase_q > BLINK_LAST_PHASE) begin
                     blink_on_q = 1'b0;
                     blink_phase_q = '0;
                  end
               end
            end
         end
         OP_STEP: begin
            if (lamp_on_q) begin
               old_level = level_q;
               if (dimming_q)
                  next_level = int'(level_q) - int'(step_size_q);
               else
                  next_level = int'(level_q) + int'(step_size_q);
               if (next_level >= int'(cmd.limit)) begin
                  level_q = cmd.limit;
                  if (old_level != cmd.limit)
                     begin_blink();
               end else if (next_level <= int'(step_size_q)) begin
                  level_q = step_size_q;
                  if (old_level != step_size_q)
                     begin_blink();
               end else begin
                  level_q = next_level[LB-1:0];
               end
               if (level_q > cmd.limit)
                  level_q = cmd.limit;
            end
         end
         OP_REVERSE: dimming_q = !dimming_q;
         OP_TURN_ON: begin
            lamp_on_q = 1'b1;
            cool_sel_q = cmd.cool_mode;
            level_q = (cmd.level_req > cmd.limit) ? cmd.limit : cmd.level_req;
         end
         OP_OFF: begin
            lamp_on_q = 1'b0;
            blink_on_q = 1'b0;
            blink_phase_q = '0;
            blink_timer_q = '0;
         end
         default: ;
      endcase
      if (lamp_on_q) begin
         if (blink_on_q)
            shown = blink_phase_q[0] ? blink_level_q : '0;
         else
            shown = level_q;
      end
      res.cool_drive = cool_sel_q ? shown : '0;
      res.warm_drive = cool_sel_q ? '0 : shown;
      res.level = level_q;
      res.lamp_on = lamp_on_q;
      res.flashing = blink_on_q;
      return res;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted == req_issued) begin
         if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_cmd = pending_q.pop_front();
            req_opcode <= next_cmd.opcode;
            req_battery_limit <= next_cmd.limit;
            req_cool_mode <= next_cmd.cool_mode;
            req_level_request <= next_cmd.level_req;
            req_valid <= 1'b1;
            req_issued++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_seen != hold_trigger) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         cycle_busy = 1'b0;
         if (req_valid && !req_stall) begin
            expected_q.push_back(lamp_update({req_opcode, req_battery_limit,
                                              req_cool_mode, req_level_request}));
            req_accepted++;
            cycle_busy = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            cycle_busy = 1'b1;
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding");
               failed = 1'b1;
            end else begin
               seen_out = expected_q.pop_front();
               if (rsp_cool_drive !== seen_out.cool_drive) begin
                  $error("cool_drive: expected %0d, got %0d",
                         seen_out.cool_drive, rsp_cool_drive);
                  failed = 1'b1;
               end
               if (rsp_warm_drive !== seen_out.warm_drive) begin
                  $error("warm_drive: expected %0d, got %0d",
                         seen_out.warm_drive, rsp_warm_drive);
                  failed = 1'b1;
               end
               if (rsp_current_level !== seen_out.level) begin
                  $error("current_level: expected %0d, got %0d",
                         seen_out.level, rsp_current_level);
                  failed = 1'b1;
               end
               if (rsp_lamp_is_on !== seen_out.lamp_on) begin
                  $error("lamp_is_on: expected %0d, got %0d",
                         seen_out.lamp_on, rsp_lamp_is_on);
                  failed = 1'b1;
               end
               if (rsp_flashing !== seen_out.flashing) begin
                  $error("flashing: expected %0d, got %0d",
                         seen_out.flashing, rsp_flashing);
                  failed = 1'b1;
               end
            end
         end
         quiet_cycles = cycle_busy ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_STEP_SIZE)
         step_size_q = value[LB-1:0];
      else
         phase_ticks_q = value[15:0];
   endtask

   task automatic queue_cmd(logic [OPCODE_BITS-1:0] op, logic [LB-1:0] lim,
                            logic mode, logic [LB-1:0] lvl);
      pending_q.push_back({op, lim, mode, lvl});
   endtask

   function automatic logic [LB-1:0] pick_limit();
      case ($urandom_range(7))
         0: return LB'($urandom_range(40));
         1: return LEVEL_FULL;
         2: return LB'($urandom_range(int'(step_size_q) + 8));
         default: return LB'($urandom_range(int'(LEVEL_FULL)));
      endcase
   endfunction

   // turn on, then a run of mostly steps and ticks; the limit may change
   task automatic queue_session(int n);
      logic [LB-1:0] lim;
      int            pick;
      lim = pick_limit();
      queue_cmd(OP_TURN_ON, lim, 1'($urandom_range(1)), LB'($urandom_range(4095)));
      for (int k = 1; k < n; k++) begin
         pick = $urandom_range(99);
         if ($urandom_range(9) == 0)
            lim = pick_limit();
         if (pick < 45)
            queue_cmd(OP_STEP, lim, 1'($urandom_range(1)), LB'($urandom_range(4095)));
         else if (pick < 72)
            queue_cmd(OP_TICK, LB'($urandom_range(4095)), 1'($urandom_range(1)),
                      LB'($urandom_range(4095)));
         else if (pick < 80)
            queue_cmd(OP_REVERSE, lim, 1'($urandom_range(1)), LB'($urandom_range(4095)));
         else if (pick < 85)
            queue_cmd(OP_TURN_ON, lim, 1'($urandom_range(1)), LB'($urandom_range(4095)));
         else if (pick < 89)
            queue_cmd(OP_OFF, lim, 1'($urandom_range(1)), LB'($urandom_range(4095)));
         else if (pick < 93)
            queue_cmd(OPCODE_BITS'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                      LB'($urandom_range(4095)), 1'($urandom_range(1)),
                      LB'($urandom_range(4095)));
         else
            queue_cmd(OPCODE_BITS'($urandom_range(7)), LB'($urandom_range(4095)),
                      1'($urandom_range(1)), LB'($urandom_range(4095)));
      end
   endtask

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_accepted != req_issued || expected_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int send_pct, int rsp_pct, logic [LB-1:0] step,
                            logic [15:0] ticks, int items, bit pressure);
      int n;
      int queued;
      write_reg(REG_STEP_SIZE, CSR_DATA_BITS'(step));
      write_reg(REG_FLASH_TICKS, CSR_DATA_BITS'(ticks));
      send_idle_pct = send_pct;
      stall_pct = rsp_pct;
      queued = 0;
      while (queued < items) begin
         n = $urandom_range(8, 30);
         queue_session(n);
         queued += n;
      end
      if (pressure) begin
         @(posedge clock);
         hold_trigger++;
      end
      wait_idle();
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // zero phase length: every tick moves the blink on
      write_reg(REG_STEP_SIZE, 32'd300);
      write_reg(REG_FLASH_TICKS, 32'd0);
      queue_cmd(OP_STEP, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_REVERSE, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_TICK, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_TURN_ON, LEVEL_FULL, 1'b1, LEVEL_FULL);
      queue_cmd(OP_STEP, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_STEP, 12'd2000, 1'b0, '0);
      queue_cmd(OP_TURN_ON, 12'd2000, 1'b0, 12'd1500);
      queue_cmd(OP_TICK, '0, 1'b1, LEVEL_FULL);
      queue_cmd(OP_TICK, '0, 1'b1, LEVEL_FULL);
      queue_cmd(OP_STEP, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_TICK, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_TICK, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_REVERSE, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_STEP, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_STEP, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_STEP, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_STEP, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_STEP, LEVEL_FULL, 1'b0, '0);
      queue_cmd(OP_STEP, 12'd100, 1'b1, LEVEL_FULL);
      queue_cmd(OP_TURN_ON, '0, 1'b1, '0);
      queue_cmd(OP_OFF, LEVEL_FULL, 1'b1, LEVEL_FULL);
      queue_cmd(OP_SPARE_FIRST, '0, 1'b0, '0);
      queue_cmd(OP_SPARE_FIRST + 3'd1, 12'd1234, 1'b1, 12'd2345);
      queue_cmd(OP_SPARE_LAST, LEVEL_FULL, 1'b1, LEVEL_FULL);
      queue_cmd(OP_STEP, '0, 1'b1, LEVEL_FULL);
      wait_idle();

      run_phase(0, 0, 12'd16, 16'd3, 96, 1'b0);
      run_phase(51, 0, 12'd1, 16'd1, 96, 1'b0);
      run_phase(0, 51, 12'd4095, 16'd2, 96, 1'b0);
      run_phase(35, 35, 12'd200, 16'd65535, 96, 1'b0);
      run_phase(0, 0, 12'd100, 16'd5, 96, 1'b1);

      repeat (4) @(posedge clock);
      if (!failed && expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
